// ===== design/ccp_pkg.sv =====
// ----------------------------------------------------------------------------
// ccp_pkg: shared types and constants for the column crack partition block
// Opcodes, default sizes, and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package ccp_pkg;

  localparam int ROWS_DEF        = 4096;
  localparam int NUM_COLS_DEF    = 4;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [1:0] OPC_WRITE = 2'd0;
  localparam logic [1:0] OPC_TWO   = 2'd1;
  localparam logic [1:0] OPC_THREE = 2'd2;
  localparam logic [1:0] OPC_READ  = 2'd3;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_X1_INC,
    DP_X2_DEC,
    DP_X3_DEC,
    DP_X1X2_STEP,
    DP_X2X3_DEC,
    DP_X3_FROM_X2,
    DP_RD_X1,
    DP_RD_X2,
    DP_RD_X3,
    DP_RD_B,
    DP_WR_CELL,
    DP_SWAP12,
    DP_SWAP23,
    DP_SWAP13,
    DP_SW_RDB,
    DP_SW_WRA,
    DP_SW_WRB,
    DP_EMIT,
    DP_EMIT_RD
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic       x1_le_x2;
    logic       x1_lt_x2;
    logic       x2_ge_x1;
    logic       x2_gt_x1;
    logic       x3_gt_x1;
    logic       x1_lt_x3;
    logic       lt_lo;
    logic       lt_hi;
    logic       rb_ok;
    logic [1:0] n_pieces;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== design/column_crack_partition_top.sv =====
// ----------------------------------------------------------------------------
// column_crack_partition_top: in-place cracking of a row store
// Row store of ids and signed columns with cell write/read and two- and
// three-way crack partitioning of a row range.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive the fields and raise start; a beat is taken at
//   the rising edge where start is high and busy is low. busy stays high
//   while the command runs and drops in the cycle that shows its last
//   result beat.
//   Result channel: each result beat is shown for one cycle with piece_valid
//   high; last_piece marks the final beat of a command. The receiver cannot
//   stall this channel, so every beat must be taken when shown.
//   A write gives no result beat; a read gives one beat.
//   A crack scans the range through one read port of the row memory, swaps
//   each row pair that must move (read both rows, write both rows, and in
//   most loops step the pointers), then emits one result beat per piece,
//   at most three beats.
//   Reset clears the sequencer and the result strobe; the row memory is not
//   cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
`default_nettype none
module column_crack_partition_top #(
  parameter int ROWS        = ccp_pkg::ROWS_DEF,
  parameter int NUM_COLS    = ccp_pkg::NUM_COLS_DEF,
  parameter int VALUE_WIDTH = ccp_pkg::VALUE_WIDTH_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire [1:0]          opcode,
  input  wire [11:0]         range_begin,
  input  wire [11:0]         range_end,
  input  wire [2:0]          column_sel,
  input  wire signed [31:0]  write_value,
  input  wire signed [31:0]  key_low,
  input  wire signed [31:0]  key_high,
  input  wire signed [31:0]  bound_lo_in,
  input  wire signed [31:0]  bound_hi_in,
  output logic               piece_valid,
  output logic [2:0]         piece_column,
  output logic [12:0]        piece_begin,
  output logic [11:0]        piece_end,
  output logic signed [31:0] piece_bound_lo,
  output logic signed [31:0] piece_bound_hi,
  output logic signed [31:0] read_data,
  output logic               last_piece
);

  // command and status between sequencer and datapath
  ccp_pkg::dp_cmd_t    cmd;
  ccp_pkg::dp_status_t status;

  ccp_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  ccp_datapath #(
    .ROWS        (ROWS),
    .NUM_COLS    (NUM_COLS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .opcode         (opcode),
    .range_begin    (range_begin),
    .range_end      (range_end),
    .column_sel     (column_sel),
    .write_value    (write_value),
    .key_low        (key_low),
    .key_high       (key_high),
    .bound_lo_in    (bound_lo_in),
    .bound_hi_in    (bound_hi_in),
    .piece_valid    (piece_valid),
    .piece_column   (piece_column),
    .piece_begin    (piece_begin),
    .piece_end      (piece_end),
    .piece_bound_lo (piece_bound_lo),
    .piece_bound_hi (piece_bound_hi),
    .read_data      (read_data),
    .last_piece     (last_piece)
  );

endmodule
`default_nettype wire

// ===== design/ccp_datapath.sv =====
// ----------------------------------------------------------------------------
// ccp_datapath: row store, scan pointers, compare and piece formatting
// Executes one command per cycle from the controller.
// ----------------------------------------------------------------------------
`default_nettype none
module ccp_datapath #(
  parameter int ROWS        = ccp_pkg::ROWS_DEF,
  parameter int NUM_COLS    = ccp_pkg::NUM_COLS_DEF,
  parameter int VALUE_WIDTH = ccp_pkg::VALUE_WIDTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  ccp_pkg::dp_cmd_t    cmd,
  output ccp_pkg::dp_status_t status,
  input  wire [1:0]           opcode,
  input  wire [11:0]          range_begin,
  input  wire [11:0]          range_end,
  input  wire [2:0]           column_sel,
  input  wire signed [31:0]   write_value,
  input  wire signed [31:0]   key_low,
  input  wire signed [31:0]   key_high,
  input  wire signed [31:0]   bound_lo_in,
  input  wire signed [31:0]   bound_hi_in,
  output logic                piece_valid,
  output logic [2:0]          piece_column,
  output logic [12:0]         piece_begin,
  output logic [11:0]         piece_end,
  output logic signed [31:0]  piece_bound_lo,
  output logic signed [31:0]  piece_bound_hi,
  output logic signed [31:0]  read_data,
  output logic                last_piece
);

  localparam int AW = $clog2(ROWS);
  localparam int PW = AW + 2;
  localparam int RW = 32 + NUM_COLS * VALUE_WIDTH;
  localparam int CW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

  typedef struct packed {
    logic signed [PW-1:0] pb;
    logic signed [PW-1:0] pe;
    logic signed [31:0]   lo;
    logic signed [31:0]   hi;
  } piece_t;

  logic [RW-1:0] mem [ROWS];
  logic [RW-1:0] rdata;
  logic [RW-1:0] bufa;
  logic [RW-1:0] wrow;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [RW-1:0] wdata;
  logic          we;

  logic [1:0]           opc_q;
  logic [2:0]           col_q;
  logic [11:0]          rbeg_q;
  logic                 rb_ok_q;
  logic signed [31:0]   wv_q, klo_q, khi_q, blo_q, bhi_q;
  logic signed [PW-1:0] b_q, e_q, x1, x2, x3, sa, sb;

  logic                 is_id;
  logic [2:0]           cidx;
  logic signed [CW-1:0] cell_val;
  piece_t               pc [3];
  logic [1:0]           npc;
  logic                 has_l, has_u, tw_one;

  assign is_id = 32'(col_q) >= 32'(NUM_COLS);
  assign cidx  = is_id ? 3'd0 : col_q;

  always_comb begin
    if (is_id) begin
      cell_val = CW'($signed(rdata[31:0]));
    end else begin
      cell_val = CW'($signed(rdata[32 + int'(cidx) * VALUE_WIDTH +: VALUE_WIDTH]));
    end
  end

  always_comb begin
    wrow = rdata;
    if (is_id) begin
      wrow[31:0] = wv_q;
    end else begin
      wrow[32 + int'(cidx) * VALUE_WIDTH +: VALUE_WIDTH] = VALUE_WIDTH'(wv_q);
    end
  end

  always_comb begin
    case (cmd.op)
      ccp_pkg::DP_RD_X1, ccp_pkg::DP_SWAP12, ccp_pkg::DP_SWAP13: raddr = x1[AW-1:0];
      ccp_pkg::DP_RD_X2, ccp_pkg::DP_SWAP23:                     raddr = x2[AW-1:0];
      ccp_pkg::DP_RD_X3:                                         raddr = x3[AW-1:0];
      ccp_pkg::DP_RD_B:                                          raddr = b_q[AW-1:0];
      ccp_pkg::DP_SW_RDB:                                        raddr = sb[AW-1:0];
      default:                                                   raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = b_q[AW-1:0];
    wdata = wrow;
    case (cmd.op)
      ccp_pkg::DP_SW_WRA: begin
        we    = 1'b1;
        waddr = sa[AW-1:0];
        wdata = rdata;
      end
      ccp_pkg::DP_SW_WRB: begin
        we    = 1'b1;
        waddr = sb[AW-1:0];
        wdata = bufa;
      end
      ccp_pkg::DP_WR_CELL: we = rb_ok_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // pointers and latched operands
  always_ff @(posedge clk) begin
    case (cmd.op)
      ccp_pkg::DP_LOAD: begin
        opc_q   <= opcode;
        col_q   <= column_sel;
        rbeg_q  <= range_begin;
        rb_ok_q <= 32'(range_begin) < 32'(ROWS);
        wv_q    <= write_value;
        klo_q   <= key_low;
        khi_q   <= key_high;
        blo_q   <= bound_lo_in;
        bhi_q   <= bound_hi_in;
        if (32'(range_begin) < 32'(ROWS)) begin
          b_q <= PW'(range_begin);
          x1  <= PW'(range_begin);
        end else begin
          b_q <= PW'(ROWS - 1);
          x1  <= PW'(ROWS - 1);
        end
        if (32'(range_end) < 32'(ROWS)) begin
          e_q <= PW'(range_end);
          x2  <= PW'(range_end);
        end else begin
          e_q <= PW'(ROWS - 1);
          x2  <= PW'(ROWS - 1);
        end
      end
      ccp_pkg::DP_X1_INC:     x1 <= x1 + PW'(1);
      ccp_pkg::DP_X2_DEC:     x2 <= x2 - PW'(1);
      ccp_pkg::DP_X3_DEC:     x3 <= x3 - PW'(1);
      ccp_pkg::DP_X1X2_STEP: begin
        x1 <= x1 + PW'(1);
        x2 <= x2 - PW'(1);
      end
      ccp_pkg::DP_X2X3_DEC: begin
        x2 <= x2 - PW'(1);
        x3 <= x3 - PW'(1);
      end
      ccp_pkg::DP_X3_FROM_X2: x3 <= x2;
      ccp_pkg::DP_SWAP12: begin
        sa <= x1;
        sb <= x2;
      end
      ccp_pkg::DP_SWAP23: begin
        sa <= x2;
        sb <= x3;
      end
      ccp_pkg::DP_SWAP13: begin
        sa <= x1;
        sb <= x3;
      end
      ccp_pkg::DP_SW_RDB: bufa <= rdata;
      default: ;
    endcase
  end

  // piece list from the final pointers
  always_comb begin
    piece_t pl, pu, pm;
    tw_one = (x1 <= b_q + PW'(1)) || (e_q <= x1);
    has_l  = x1 > b_q;
    has_u  = e_q > x2 + PW'(1);
    pl = '{pb: b_q, pe: x1, lo: blo_q, hi: klo_q};
    pu = '{pb: x2 + PW'(1), pe: e_q, lo: khi_q, hi: bhi_q};
    pm.pb = has_l ? x1 + PW'(1) : b_q;
    pm.lo = has_l ? klo_q : blo_q;
    pm.pe = has_u ? x2 : e_q;
    pm.hi = has_u ? khi_q : bhi_q;
    pc[0] = pm;
    pc[1] = pm;
    pc[2] = pm;
    npc   = 2'd1;
    if (opc_q == ccp_pkg::OPC_TWO) begin
      if (tw_one) begin
        pc[0] = '{pb: b_q, pe: e_q, lo: blo_q, hi: bhi_q};
      end else begin
        pc[0] = '{pb: x1, pe: e_q, lo: klo_q, hi: bhi_q};
        pc[1] = '{pb: b_q, pe: x1 - PW'(1), lo: blo_q, hi: klo_q};
        npc   = 2'd2;
      end
    end else begin
      case ({has_l, has_u})
        2'b11: begin
          pc[0] = pl;
          pc[1] = pu;
          npc   = 2'd3;
        end
        2'b10: begin
          pc[0] = pl;
          npc   = 2'd2;
        end
        2'b01: begin
          pc[0] = pu;
          npc   = 2'd2;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status.x1_le_x2 = x1 <= x2;
    status.x1_lt_x2 = x1 < x2;
    status.x2_ge_x1 = x2 >= x1;
    status.x2_gt_x1 = x2 > x1;
    status.x3_gt_x1 = x3 > x1;
    status.x1_lt_x3 = x1 < x3;
    status.lt_lo    = cell_val < CW'(klo_q);
    status.lt_hi    = cell_val < CW'(khi_q);
    status.rb_ok    = rb_ok_q;
    status.n_pieces = npc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      piece_valid <= 1'b0;
    end else begin
      piece_valid <= (cmd.op == ccp_pkg::DP_EMIT) || (cmd.op == ccp_pkg::DP_EMIT_RD);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ccp_pkg::DP_EMIT_RD) begin
      piece_column   <= col_q;
      piece_begin    <= 13'(rbeg_q);
      piece_end      <= rbeg_q;
      piece_bound_lo <= '0;
      piece_bound_hi <= '0;
      read_data      <= rb_ok_q ? 32'(cell_val) : 32'sd0;
      last_piece     <= 1'b1;
    end else if (cmd.op == ccp_pkg::DP_EMIT) begin
      piece_column   <= col_q;
      piece_begin    <= 13'(pc[cmd.k].pb);
      piece_end      <= 12'(pc[cmd.k].pe);
      piece_bound_lo <= pc[cmd.k].lo;
      piece_bound_hi <= pc[cmd.k].hi;
      read_data      <= '0;
      last_piece     <= (cmd.k == npc - 2'd1);
    end
  end

endmodule
`default_nettype wire

// ===== design/ccp_controller.sv =====
// ----------------------------------------------------------------------------
// ccp_controller: sequencer for cell access and crack partitioning
// Walks the scan loops, calls the row swap sequence and emits pieces.
// ----------------------------------------------------------------------------
`default_nettype none
module ccp_controller (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire [1:0]           opcode,
  output logic                busy,
  output ccp_pkg::dp_cmd_t    cmd,
  input  ccp_pkg::dp_status_t status
);

  typedef enum logic [22:0] {
    ST_IDLE   = 23'd1 << 0,
    ST_WR_RD  = 23'd1 << 1,
    ST_WR_WB  = 23'd1 << 2,
    ST_RD_RD  = 23'd1 << 3,
    ST_RD_EM  = 23'd1 << 4,
    ST_T_TOP  = 23'd1 << 5,
    ST_T_A    = 23'd1 << 6,
    ST_T_IN   = 23'd1 << 7,
    ST_T_B    = 23'd1 << 8,
    ST_T_AFT  = 23'd1 << 9,
    ST_T_POST = 23'd1 << 10,
    ST_S1_TOP = 23'd1 << 11,
    ST_S1_D   = 23'd1 << 12,
    ST_S2_INI = 23'd1 << 13,
    ST_L_TOP  = 23'd1 << 14,
    ST_L_D    = 23'd1 << 15,
    ST_L_POST = 23'd1 << 16,
    ST_M_TOP  = 23'd1 << 17,
    ST_M_D    = 23'd1 << 18,
    ST_SW_B   = 23'd1 << 19,
    ST_SW_WA  = 23'd1 << 20,
    ST_SW_WB  = 23'd1 << 21,
    ST_EMIT   = 23'd1 << 22
  } state_t;

  state_t     state, state_next, ret, ret_next;
  logic [1:0] k, k_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    k_next     = k;
    cmd.op     = ccp_pkg::DP_NOP;
    cmd.k      = k;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.op = ccp_pkg::DP_LOAD;
          unique case (opcode)
            ccp_pkg::OPC_WRITE: state_next = ST_WR_RD;
            ccp_pkg::OPC_TWO:   state_next = ST_T_TOP;
            ccp_pkg::OPC_THREE: state_next = ST_S1_TOP;
            default:            state_next = ST_RD_RD;
          endcase
        end
      end
      ST_WR_RD: begin
        if (status.rb_ok) begin
          cmd.op     = ccp_pkg::DP_RD_B;
          state_next = ST_WR_WB;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WR_WB: begin
        cmd.op     = ccp_pkg::DP_WR_CELL;
        state_next = ST_IDLE;
      end
      ST_RD_RD: begin
        cmd.op     = ccp_pkg::DP_RD_B;
        state_next = ST_RD_EM;
      end
      ST_RD_EM: begin
        cmd.op     = ccp_pkg::DP_EMIT_RD;
        state_next = ST_IDLE;
      end
      ST_T_TOP: begin
        if (!status.x1_le_x2) begin
          k_next     = 2'd0;
          state_next = ST_EMIT;
        end else begin
          cmd.op     = ccp_pkg::DP_RD_X1;
          state_next = ST_T_A;
        end
      end
      ST_T_A: begin
        if (status.lt_lo) begin
          cmd.op     = ccp_pkg::DP_X1_INC;
          state_next = ST_T_TOP;
        end else begin
          state_next = ST_T_IN;
        end
      end
      ST_T_IN: begin
        if (status.x2_ge_x1) begin
          cmd.op     = ccp_pkg::DP_RD_X2;
          state_next = ST_T_B;
        end else begin
          state_next = ST_T_AFT;
        end
      end
      ST_T_B: begin
        if (!status.lt_lo) begin
          cmd.op     = ccp_pkg::DP_X2_DEC;
          state_next = ST_T_IN;
        end else begin
          state_next = ST_T_AFT;
        end
      end
      ST_T_AFT: begin
        if (status.x1_lt_x2) begin
          cmd.op     = ccp_pkg::DP_SWAP12;
          ret_next   = ST_T_POST;
          state_next = ST_SW_B;
        end else begin
          state_next = ST_T_TOP;
        end
      end
      ST_T_POST: begin
        cmd.op     = ccp_pkg::DP_X1X2_STEP;
        state_next = ST_T_TOP;
      end
      ST_S1_TOP: begin
        if (status.x2_gt_x1) begin
          cmd.op     = ccp_pkg::DP_RD_X2;
          state_next = ST_S1_D;
        end else begin
          state_next = ST_S2_INI;
        end
      end
      ST_S1_D: begin
        if (!status.lt_hi) begin
          cmd.op     = ccp_pkg::DP_X2_DEC;
          state_next = ST_S1_TOP;
        end else begin
          state_next = ST_S2_INI;
        end
      end
      ST_S2_INI: begin
        cmd.op     = ccp_pkg::DP_X3_FROM_X2;
        state_next = ST_L_TOP;
      end
      ST_L_TOP: begin
        if (status.x3_gt_x1) begin
          cmd.op     = ccp_pkg::DP_RD_X3;
          state_next = ST_L_D;
        end else begin
          state_next = ST_M_TOP;
        end
      end
      ST_L_D: begin
        if (status.lt_lo) begin
          state_next = ST_M_TOP;
        end else if (!status.lt_hi) begin
          cmd.op     = ccp_pkg::DP_SWAP23;
          ret_next   = ST_L_POST;
          state_next = ST_SW_B;
        end else begin
          cmd.op     = ccp_pkg::DP_X3_DEC;
          state_next = ST_L_TOP;
        end
      end
      ST_L_POST: begin
        cmd.op     = ccp_pkg::DP_X2X3_DEC;
        state_next = ST_L_TOP;
      end
      ST_M_TOP: begin
        if (status.x1_lt_x3) begin
          cmd.op     = ccp_pkg::DP_RD_X1;
          state_next = ST_M_D;
        end else begin
          k_next     = 2'd0;
          state_next = ST_EMIT;
        end
      end
      ST_M_D: begin
        if (status.lt_lo) begin
          cmd.op     = ccp_pkg::DP_X1_INC;
          state_next = ST_M_TOP;
        end else begin
          cmd.op     = ccp_pkg::DP_SWAP13;
          ret_next   = ST_L_TOP;
          state_next = ST_SW_B;
        end
      end
      ST_SW_B: begin
        cmd.op     = ccp_pkg::DP_SW_RDB;
        state_next = ST_SW_WA;
      end
      ST_SW_WA: begin
        cmd.op     = ccp_pkg::DP_SW_WRA;
        state_next = ST_SW_WB;
      end
      ST_SW_WB: begin
        cmd.op     = ccp_pkg::DP_SW_WRB;
        state_next = ret;
      end
      ST_EMIT: begin
        cmd.op = ccp_pkg::DP_EMIT;
        if (k == status.n_pieces - 2'd1) begin
          state_next = ST_IDLE;
        end else begin
          k_next = k + 2'd1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
      k     <= 2'd0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      k     <= k_next;
    end
  end

  a_swap_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SW_WB) |-> ($past(state) == ST_SW_WA))
    else $error("swap write-back out of order");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (k < status.n_pieces))
    else $error("piece index beyond piece count");

endmodule
`default_nettype wire
